FILE: src/u8v_pkg.sv
package u8v_pkg;

  localparam logic [7:0] CONT_BASE     = 8'h80;
  localparam logic [7:0] LEAD2_BASE    = 8'hC0;
  localparam logic [7:0] LEAD3_BASE    = 8'hE0;
  localparam logic [7:0] LEAD4_BASE    = 8'hF0;
  localparam logic [7:0] DIGIT_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI      = 8'h39;
  localparam logic [7:0] LOWER_LO      = 8'h61;
  localparam logic [7:0] LOWER_HI      = 8'h7A;
  localparam logic [7:0] UPPER_LO      = 8'h41;
  localparam logic [7:0] UPPER_HI      = 8'h5A;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_FILTER_ON     = 2'd0;
  localparam logic [1:0] REG_ALLOW_DIGITS  = 2'd1;
  localparam logic [1:0] REG_ALLOW_LETTERS = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       no_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic ascii_filter_on;
    logic allow_digits;
    logic allow_letters;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic string_valid;
  } result_t;

  function automatic logic ascii_ok(input logic [7:0] b, input cfg_t cfg);
    logic ok;
    ok = 1'b0;
    if (!cfg.ascii_filter_on) begin
      ok = 1'b1;
    end else if (b inside {[DIGIT_LO:DIGIT_HI]}) begin
      ok = cfg.allow_digits;
    end else if (b inside {[LOWER_LO:LOWER_HI], [UPPER_LO:UPPER_HI]}) begin
      ok = cfg.allow_letters;
    end
    return ok;
  endfunction

endpackage

FILE: src/u8v_in_reg.sv
module u8v_in_reg
  import u8v_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: src/u8v_check.sv
module u8v_check
  import u8v_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [1:0] bytes_still_expected;
  logic       sequence_bad;
  logic       string_failed;
  logic [1:0] bytes_still_expected_next;
  logic       sequence_bad_next;
  logic       string_failed_next;
  logic [7:0] b;
  logic       cont;

  assign b    = item.byte_value;
  assign cont = (b & LEAD2_BASE) == CONT_BASE;

  always_comb begin
    bytes_still_expected_next = bytes_still_expected;
    sequence_bad_next         = sequence_bad;
    string_failed_next        = string_failed;
    if (!item.no_byte && !string_failed) begin
      if (bytes_still_expected != 2'd0) begin
        bytes_still_expected_next = bytes_still_expected - 2'd1;
        if (bytes_still_expected == 2'd1) begin
          if (!cont || sequence_bad) string_failed_next = 1'b1;
          sequence_bad_next = 1'b0;
        end else if (!cont) begin
          sequence_bad_next = 1'b1;
        end
      end else if (b < CONT_BASE) begin
        if (!ascii_ok(b, cfg)) string_failed_next = 1'b1;
      end else if (b < LEAD2_BASE) begin
        string_failed_next = 1'b1;
      end else if (b < LEAD3_BASE) begin
        bytes_still_expected_next = 2'd1;
        sequence_bad_next         = 1'b0;
      end else if (b < LEAD4_BASE) begin
        bytes_still_expected_next = 2'd2;
        sequence_bad_next         = 1'b0;
      end else begin
        string_failed_next = 1'b1;
      end
    end
  end

  always_comb begin
    result.valid        = fire && item.end_of_string;
    result.string_valid = !string_failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_still_expected <= 2'd0;
      sequence_bad         <= 1'b0;
      string_failed        <= 1'b0;
    end else if (fire) begin
      if (item.end_of_string) begin
        bytes_still_expected <= 2'd0;
        sequence_bad         <= 1'b0;
        string_failed        <= 1'b0;
      end else begin
        bytes_still_expected <= bytes_still_expected_next;
        sequence_bad         <= sequence_bad_next;
        string_failed        <= string_failed_next;
      end
    end
  end

endmodule

FILE: src/u8v_out_reg.sv
module u8v_out_reg
  import u8v_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  result_t result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_string_valid
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && result.valid) begin
      out_string_valid <= result.string_valid;
    end
  end

endmodule

FILE: src/utf8_byte_stream_validator.sv
// UTF-8 byte stream validator.
// Input stream: one byte per request on s_tdata; s_tuser set means the request
// carries no byte (used to close an empty string); s_tlast marks the last
// request of a string. Output stream: one verdict per string on m_tdata[0]
// (1 = string passed), sent after the request that carried s_tlast.
// Config: APB registers at 0x0 ascii_filter_on, 0x4 allow_digits,
// 0x8 allow_letters; write only while no string is in flight.
// Throughput: one request per cycle unless a closing request waits for the result
// register; the input register feeds the per-byte check and state update.
// Verdict path: the closing request is registered in the input register, and
// the check loads its verdict into the result register, which drives m_tvalid.
// Reset: clears string state and both valid flags; registers return to
// filter off, digits and letters allowed.
// Stall: while m_tready is low the verdict holds in the result register;
// bytes without s_tlast keep flowing, and the next closing request waits in
// the input register, which then backpressures s_tready.
module utf8_byte_stream_validator
  import u8v_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] byte_value
  input  logic              s_tuser,   // [0] no_byte
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [0] string_valid, [7:1] zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    fire;
  logic    free;
  result_t result;
  logic    string_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ascii_filter_on <= 1'b0;
      cfg.allow_digits    <= 1'b1;
      cfg.allow_letters   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_FILTER_ON:     cfg.ascii_filter_on <= pwdata[0];
        REG_ALLOW_DIGITS:  cfg.allow_digits    <= pwdata[0];
        REG_ALLOW_LETTERS: cfg.allow_letters   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[3:2])
      REG_FILTER_ON:     prdata[0] = cfg.ascii_filter_on;
      REG_ALLOW_DIGITS:  prdata[0] = cfg.allow_digits;
      REG_ALLOW_LETTERS: prdata[0] = cfg.allow_letters;
      default:           prdata    = 32'd0;
    endcase
  end

  assign in_item.byte_value    = s_tdata;
  assign in_item.no_byte       = s_tuser;
  assign in_item.end_of_string = s_tlast;

  assign fire = held_valid && (!held_item.end_of_string || free);

  u8v_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  u8v_check u_check (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

  u8v_out_reg u_out_reg (
    .clk              (clk),
    .rst              (rst),
    .result           (result),
    .free             (free),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_string_valid (string_valid)
  );

  assign m_tdata = {7'd0, string_valid};

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import u8v_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 4;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [7:0] byte_value
  logic              s_tuser  = 1'b0; // [0] no_byte
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [0] string_valid, [7:1] zero
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  utf8_byte_stream_validator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_t       byte_queue[$];
  logic        verdicts_due[$];
  cfg_t        filter_cfg = '{ascii_filter_on: 1'b0, allow_digits: 1'b1, allow_letters: 1'b1};
  logic [1:0]  cont_due   = '0;
  logic        seq_broken = 1'b0;
  logic        str_failed = 1'b0;
  logic        calm       = 1'b0;
  int unsigned reqs_open = 0, reqs_taken = 0, queued = 0;
  int unsigned strings_done = 0, strings_passed = 0, errors = 0, cycles = 0;
  int unsigned settings = 1;

  function automatic logic ascii_allowed(logic [7:0] b);
    if (!filter_cfg.ascii_filter_on) return 1'b1;
    if (b >= DIGIT_LO && b <= DIGIT_HI) return filter_cfg.allow_digits;
    if ((b >= LOWER_LO && b <= LOWER_HI) || (b >= UPPER_LO && b <= UPPER_HI))
      return filter_cfg.allow_letters;
    return 1'b0;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    logic is_cont;
    is_cont = (b[7:6] == 2'b10);
    if (str_failed) return;
    if (cont_due != 0) begin
      cont_due = cont_due - 2'd1;
      if (cont_due == 0) begin
        if (!is_cont || seq_broken) str_failed = 1'b1;
        seq_broken = 1'b0;
      end else if (!is_cont) begin
        seq_broken = 1'b1;
      end
    end else if (b < CONT_BASE) begin
      if (!ascii_allowed(b)) str_failed = 1'b1;
    end else if (b < LEAD2_BASE) begin
      str_failed = 1'b1;
    end else if (b < LEAD3_BASE) begin
      cont_due   = 2'd1;
      seq_broken = 1'b0;
    end else if (b < LEAD4_BASE) begin
      cont_due   = 2'd2;
      seq_broken = 1'b0;
    end else begin
      str_failed = 1'b1;
    end
  endfunction

  function automatic void take_request(logic [7:0] b, logic nb, logic last);
    if (!nb) absorb_byte(b);
    if (last) begin
      verdicts_due.push_back(!str_failed);
      cont_due   = '0;
      seq_broken = 1'b0;
      str_failed = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : driver
    item_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_request(s_tdata, s_tuser, s_tlast);
        reqs_open--;
        reqs_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          req = byte_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= req.byte_value;
          s_tuser  <= req.no_byte;
          s_tlast  <= req.end_of_string;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 19);
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict: expected none, actual %0h", $time, m_tdata);
        end else begin
          want = verdicts_due.pop_front();
          strings_done++;
          if (want) strings_passed++;
          if (m_tdata !== {7'b0, want}) begin
            errors++;
            $display("%0t: verdict mismatch: expected %0h, actual %0h",
                     $time, {7'b0, want}, m_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_req(logic [7:0] b, logic nb, logic last);
    item_t r;
    r.byte_value    = b;
    r.no_byte       = nb;
    r.end_of_string = last;
    byte_queue.push_back(r);
    reqs_open++;
    if (!nb || last) queued++;
  endtask

  // bytes go out lowest first; the last one closes the string
  task automatic add_word(int unsigned n, logic [31:0] packed_bytes);
    for (int unsigned i = 0; i < n; i++)
      push_req(packed_bytes[8*i +: 8], 1'b0, i == n - 1);
  endtask

  function automatic logic [7:0] pick_ascii();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(DIGIT_LO, DIGIT_HI));
      1:       return 8'($urandom_range(UPPER_LO, UPPER_HI));
      2:       return 8'($urandom_range(LOWER_LO, LOWER_HI));
      default: return 8'($urandom_range(CONT_BASE - 1));
    endcase
  endfunction

  task automatic add_string();
    logic [7:0]  seq[$];
    int unsigned nchars, k, n;
    logic        close_apart;
    if ($urandom_range(15) == 0) begin
      push_req(8'($urandom), 1'b1, 1'b1);
      return;
    end
    nchars = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) begin
      repeat (nchars) seq.push_back(8'($urandom));
    end else begin
      repeat (nchars) begin
        k = $urandom_range(9);
        if (k < 5) begin
          seq.push_back(pick_ascii());
        end else begin
          seq.push_back(k < 8 ? 8'($urandom_range(LEAD2_BASE, LEAD3_BASE - 1))
                              : 8'($urandom_range(LEAD3_BASE, LEAD4_BASE - 1)));
          repeat (k < 8 ? 1 : 2) seq.push_back({2'b10, 6'($urandom)});
        end
      end
      // corrupt, cut short or pad some of the well-formed strings
      case ($urandom_range(9))
        7: seq[$urandom_range(seq.size() - 1)] = 8'($urandom);
        8: repeat ($urandom_range(1, 2)) if (seq.size() > 1) void'(seq.pop_back());
        9: seq.insert($urandom_range(seq.size()), 8'($urandom));
        default: ;
      endcase
    end
    n = seq.size();
    close_apart = ($urandom_range(3) == 0);
    foreach (seq[i]) begin
      if ($urandom_range(11) == 0) push_req(8'($urandom), 1'b1, 1'b0);
      push_req(seq[i], 1'b0, !close_apart && i == n - 1);
    end
    if (close_apart) push_req(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic add_random(int unsigned count);
    int unsigned start;
    start = queued;
    while (queued - start < count) add_string();
  endtask

  task automatic apb_write(logic [1:0] idx, logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILTER_ON:     filter_cfg.ascii_filter_on = v;
      REG_ALLOW_DIGITS:  filter_cfg.allow_digits    = v;
      REG_ALLOW_LETTERS: filter_cfg.allow_letters   = v;
      default: ;
    endcase
  endtask

  task automatic set_filter(logic f, logic d, logic l);
    apb_write(REG_FILTER_ON, f);
    apb_write(REG_ALLOW_DIGITS, d);
    apb_write(REG_ALLOW_LETTERS, l);
    settings++;
  endtask

  task automatic drain();
    while (reqs_open != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_req(8'hA5, 1'b1, 1'b1);
    add_word(2, 32'h7F00);
    add_word(1, 32'h80);
    add_word(1, 32'hBF);
    add_word(2, 32'h80C0);
    add_word(2, 32'h3FDF);
    add_word(3, 32'hBF80E0);
    add_word(3, 32'h8000EF);
    add_word(1, 32'hF0);
    add_word(2, 32'h41FF);
    add_word(2, 32'h80E1);
    push_req(8'h41, 1'b0, 1'b0);
    push_req(8'h5A, 1'b1, 1'b0);
    push_req(8'hC2, 1'b0, 1'b1);
    drain();
    add_random(200);
    drain();

    set_filter(1'b1, 1'b1, 1'b1);
    add_word(4, 32'h5A413930);
    add_word(2, 32'h7A61);
    add_word(1, 32'h2F);
    add_word(1, 32'h3A);
    add_word(1, 32'h40);
    add_word(1, 32'h5B);
    add_word(1, 32'h60);
    add_word(1, 32'h7B);
    add_word(3, 32'h8080E0);
    add_random(110);
    drain();

    set_filter(1'b1, 1'b0, 1'b1);
    add_random(100);
    drain();

    set_filter(1'b1, 1'b1, 1'b0);
    add_random(100);
    drain();

    set_filter(1'b1, 1'b0, 1'b0);
    apb_write(REG_UNUSED, 1'b1);
    add_random(80);
    drain();

    set_filter(1'b0, 1'b0, 1'b0);
    calm <= 1'b1;
    add_random(130);
    drain();

    $display("Checked %0d string verdicts (%0d valid, %0d invalid) from %0d requests",
             strings_done, strings_passed, strings_done - strings_passed, reqs_taken);
    $display("Filter settings run: %0d, from all classes allowed down to none", settings);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
